FILE: hw/rtl/spsr_pkg.sv
// spsr_pkg: widths, codes, constants and the speed step table of the
// stepper pulse speed regulator
// no dependencies; used by the channel interfaces and the top level
package spsr_pkg;

    // payload field widths
    localparam int SCALE_W  = 16;
    localparam int MODE_W   = 2;
    localparam int MOTOR_W  = 4;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 16;
    localparam int SPEED_W  = 7;
    localparam int DELTA_W  = 4;

    // group state widths
    localparam int LAST_W = 18;
    localparam int MISS_W = 32;

    // motor grouping
    localparam int GROUP_SPLIT = 8;
    localparam int MOTOR_COUNT = 16;

    // target period: scale * 100 / wanted speed
    localparam int SCALE_MUL = 100;
    localparam int TARGET_W  = 23;
    localparam int X_W       = TARGET_W + 2;
    localparam int PREV_SHIFT = 2;

    // critical miss counts before the divide by wanted speed
    localparam int CRIT_SHORT = 7 * 150;
    localparam int CRIT_LONG  = 28 * 150;
    localparam int CRIT_W     = 13;
    // full-speed period is sixteen critical counts
    localparam int FULL_SHIFT = 4;

    // delta shaping
    localparam int DELTA_DIV   = 5;
    localparam int DELTA_LIMIT = 5;
    localparam int DELTA_SAT   = DELTA_DIV * DELTA_LIMIT;

    // end of move
    localparam int NEAR_END       = 5;
    localparam int FAST_LIMIT     = 50;
    localparam int END_SPEED_FAST = 5;
    localparam int END_SPEED_SLOW = 20;
    localparam int MAX_SPEED      = 100;

    // shared divider
    localparam int DVD_W = MISS_W;
    localparam int DSR_W = CRIT_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PULSE = 2'd0,
        MODE_MISS  = 2'd1,
        MODE_RESET = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic {
        CMD_ABS   = 1'b0,
        CMD_DELTA = 1'b1
    } cmd_t;

    // speed step table
    localparam int STEP_N = 15;
    localparam logic [SPEED_W-1:0] STEP_LIMIT [STEP_N] = '{
        7'd40, 7'd43, 7'd46, 7'd50, 7'd53, 7'd56, 7'd60, 7'd64,
        7'd68, 7'd72, 7'd76, 7'd80, 7'd84, 7'd88, 7'd90
    };
    localparam logic [SPEED_W-1:0] STEP_SPEED [STEP_N] = '{
        7'd43, 7'd46, 7'd50, 7'd53, 7'd56, 7'd60, 7'd64, 7'd68,
        7'd72, 7'd76, 7'd80, 7'd84, 7'd88, 7'd90, 7'd92
    };

    typedef struct packed {
        logic               hit;
        logic [SPEED_W-1:0] value;
    } step_t;

    // first table entry whose limit lies above the current speed
    function automatic step_t step_lookup(input logic [SPEED_W-1:0] speed);
        step_t r;
        r.hit   = 1'b0;
        r.value = '0;
        for (int i = STEP_N - 1; i >= 0; i--)
        begin
            if (speed < STEP_LIMIT[i])
            begin
                r.hit   = 1'b1;
                r.value = STEP_SPEED[i];
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/spsr_ifs.sv
// spsr channel interfaces: configuration write, pulse event in, command out
// depends on spsr_pkg for the field widths

// configuration write channel, period scale only
interface spsr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [spsr_pkg::SCALE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// pulse event channel
interface spsr_pulse_if;
    logic                          valid;
    logic                          ready;
    logic [spsr_pkg::MODE_W-1:0]   mode;
    logic [spsr_pkg::MOTOR_W-1:0]  motor_index;
    logic [spsr_pkg::PERIOD_W-1:0] pulse_period;
    logic [spsr_pkg::COUNT_W-1:0]  pulse_count;
    logic [spsr_pkg::COUNT_W-1:0]  requested_count;
    logic [spsr_pkg::SPEED_W-1:0]  wanted_speed;
    logic [spsr_pkg::SPEED_W-1:0]  current_speed;
    logic                          high_too_long;

    modport source (output valid, output mode, output motor_index, output pulse_period,
                    output pulse_count, output requested_count, output wanted_speed,
                    output current_speed, output high_too_long, input ready);
    modport sink   (input valid, input mode, input motor_index, input pulse_period,
                    input pulse_count, input requested_count, input wanted_speed,
                    input current_speed, input high_too_long, output ready);
endinterface

// speed command channel
interface spsr_result_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [spsr_pkg::MOTOR_W-1:0]        target_motor;
    logic [spsr_pkg::SPEED_W-1:0]        speed_value;
    logic signed [spsr_pkg::DELTA_W-1:0] speed_delta;
    logic                                divide_error;

    modport source (output valid, output command, output target_motor, output speed_value,
                    output speed_delta, output divide_error, input ready);
    modport sink   (input valid, input command, input target_motor, input speed_value,
                    input speed_delta, input divide_error, output ready);
endinterface

FILE: hw/rtl/stepper_pulse_speed_regulator_unit.sv
// stepper_pulse_speed_regulator_unit: turns pulse and missed-pulse events
// into speed commands through one shared restoring divider
// depends on spsr_pkg and the channel interfaces in spsr_ifs.sv
//
//   channel  | dir | transaction
//   ---------+-----+-----------------------------------------------
//   cfg      | in  | period scale write, taken in any cycle
//   pulse    | in  | one pulse event: mode, motor, period, counts
//   result   | out | zero or one speed command per event
//
// one divider produces one quotient bit per cycle and sets the timing:
// measured pulse 23 divide steps, missed pulse 13 steps for the critical
// count, then at most two 32-step modulo passes; a zero wanted speed, group
// reset, ignored events and zero periods take no divide steps.
// pulse.ready is high only while the sequencer is idle; a command waits in
// the output register, so a stalled result only holds the block once the
// next command is ready. reset sets period scale to 1 and group state to -1.
module stepper_pulse_speed_regulator_unit (
    input  logic           clk,
    input  logic           rst_n,
    spsr_cfg_if.sink       cfg,
    spsr_pulse_if.sink     pulse,
    spsr_result_if.source  result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TARGET,
        ST_EVAL0,
        ST_EVAL1,
        ST_CRIT,
        ST_CNT,
        ST_MODA,
        ST_MODB,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration and group state
    logic        [spsr_pkg::SCALE_W-1:0] scale_reg;
    logic signed [spsr_pkg::LAST_W-1:0]  last_a_reg;
    logic signed [spsr_pkg::LAST_W-1:0]  last_b_reg;
    logic        [spsr_pkg::MISS_W-1:0]  miss_a_reg;
    logic        [spsr_pkg::MISS_W-1:0]  miss_b_reg;

    // latched event fields
    logic [spsr_pkg::MOTOR_W-1:0]  motor_reg;
    logic                          group_a_reg;
    logic [spsr_pkg::PERIOD_W-1:0] period_reg;
    logic [spsr_pkg::COUNT_W-1:0]  item_count_reg;
    logic [spsr_pkg::COUNT_W-1:0]  requested_reg;
    logic [spsr_pkg::SPEED_W-1:0]  speed_reg;

    // shared divider
    logic [spsr_pkg::DVD_W-1:0] div_dvd_reg;
    logic [spsr_pkg::DSR_W-1:0] div_dsr_reg;
    logic [spsr_pkg::DSR_W-1:0] div_rem_reg;
    logic [spsr_pkg::CNT_W-1:0] div_cnt_reg;
    logic [spsr_pkg::DVD_W-1:0] div_dvd_next;
    logic [spsr_pkg::DSR_W-1:0] div_rem_next;
    logic [spsr_pkg::DSR_W:0]   div_rem_shift;
    logic                       div_fit;
    logic                       div_last;

    // working values
    logic        [spsr_pkg::MISS_W-1:0] c_reg;
    logic signed [spsr_pkg::X_W-1:0]    dev_reg;
    logic signed [spsr_pkg::X_W-1:0]    q4_reg;

    // command built by the sequencer
    spsr_pkg::cmd_t                     pend_cmd_reg;
    logic        [spsr_pkg::SPEED_W-1:0] pend_value_reg;
    logic signed [spsr_pkg::DELTA_W-1:0] pend_delta_reg;
    logic                                pend_err_reg;

    // output register
    logic                                out_valid_reg;
    spsr_pkg::cmd_t                      out_cmd_reg;
    logic        [spsr_pkg::MOTOR_W-1:0] out_motor_reg;
    logic        [spsr_pkg::SPEED_W-1:0] out_value_reg;
    logic signed [spsr_pkg::DELTA_W-1:0] out_delta_reg;
    logic                                out_err_reg;

    // accept side
    logic                                in_fire;
    logic                                motor_ok;
    logic                                group_in;
    logic [spsr_pkg::TARGET_W-1:0]       scaled;
    logic [spsr_pkg::CRIT_W-1:0]         crit_num;
    spsr_pkg::mode_t                     in_mode;

    // measured pulse evaluation
    logic        [spsr_pkg::TARGET_W-1:0] target;
    logic signed [spsr_pkg::X_W-1:0]      target_x;
    logic signed [spsr_pkg::X_W-1:0]      period_x;
    logic signed [spsr_pkg::X_W-1:0]      last_x;
    logic signed [spsr_pkg::X_W-1:0]      prev;
    logic signed [spsr_pkg::X_W-1:0]      prev_adj;
    logic signed [spsr_pkg::X_W-1:0]      x;
    logic        [spsr_pkg::SPEED_W-1:0]  ax;
    logic        [spsr_pkg::DELTA_W-1:0]  q;
    logic signed [spsr_pkg::DELTA_W-1:0]  delta;
    logic signed [spsr_pkg::COUNT_W:0]    req_gap;
    logic                                 near_end;

    // missed pulse evaluation
    logic [spsr_pkg::CRIT_W-1:0] crit;
    logic [spsr_pkg::MISS_W-1:0] miss_sel;
    logic [spsr_pkg::MISS_W-1:0] c_new;
    logic [spsr_pkg::MISS_W-1:0] abs0;
    logic [spsr_pkg::MISS_W-1:0] abs1;
    spsr_pkg::step_t             step;

    // handshakes
    assign cfg.ready   = 1'b1;
    assign pulse.ready = (state_reg == ST_IDLE);
    assign in_fire     = pulse.valid && pulse.ready;

    assign result.valid        = out_valid_reg;
    assign result.command      = out_cmd_reg;
    assign result.target_motor = out_motor_reg;
    assign result.speed_value  = out_value_reg;
    assign result.speed_delta  = out_delta_reg;
    assign result.divide_error = out_err_reg;

    // event decode
    assign in_mode  = spsr_pkg::mode_t'(pulse.mode);
    assign motor_ok = 32'(pulse.motor_index) < 32'(spsr_pkg::MOTOR_COUNT);
    assign group_in = 32'(pulse.motor_index) < 32'(spsr_pkg::GROUP_SPLIT);
    assign scaled   = spsr_pkg::TARGET_W'(scale_reg)
                    * spsr_pkg::TARGET_W'(spsr_pkg::SCALE_MUL);
    assign crit_num = pulse.high_too_long ? spsr_pkg::CRIT_W'(spsr_pkg::CRIT_SHORT)
                                          : spsr_pkg::CRIT_W'(spsr_pkg::CRIT_LONG);

    // one restoring divide step
    assign div_rem_shift = {div_rem_reg, div_dvd_reg[spsr_pkg::DVD_W-1]};
    assign div_fit       = div_rem_shift >= {1'b0, div_dsr_reg};
    assign div_rem_next  = div_fit
                         ? spsr_pkg::DSR_W'(div_rem_shift - {1'b0, div_dsr_reg})
                         : div_rem_shift[spsr_pkg::DSR_W-1:0];
    assign div_dvd_next  = {div_dvd_reg[spsr_pkg::DVD_W-2:0], div_fit};
    assign div_last      = (div_cnt_reg == spsr_pkg::CNT_W'(1));

    // error terms of a measured pulse
    always_comb
    begin
        target   = div_dvd_reg[spsr_pkg::TARGET_W-1:0];
        target_x = spsr_pkg::X_W'(target);
        period_x = spsr_pkg::X_W'(period_reg);
        last_x   = spsr_pkg::X_W'(group_a_reg ? last_a_reg : last_b_reg);
        if (item_count_reg > spsr_pkg::COUNT_W'(1))
            prev = last_x - target_x;
        else
            prev = '0;
        // quarter rounded toward zero
        prev_adj = prev + (prev[spsr_pkg::X_W-1]
                 ? spsr_pkg::X_W'((1 << spsr_pkg::PREV_SHIFT) - 1) : '0);
    end

    // delta scaling and clamp
    always_comb
    begin
        x  = dev_reg - q4_reg;
        ax = '0;
        q  = '0;
        if (x >= spsr_pkg::X_W'(spsr_pkg::DELTA_SAT))
            delta = spsr_pkg::DELTA_W'(spsr_pkg::DELTA_LIMIT);
        else if (x <= -spsr_pkg::X_W'(spsr_pkg::DELTA_SAT))
            delta = -spsr_pkg::DELTA_W'(spsr_pkg::DELTA_LIMIT);
        else
        begin
            ax = x[spsr_pkg::X_W-1] ? spsr_pkg::SPEED_W'(-x) : spsr_pkg::SPEED_W'(x);
            for (int k = 1; k < spsr_pkg::DELTA_LIMIT; k++)
            begin
                if (ax >= spsr_pkg::SPEED_W'(k * spsr_pkg::DELTA_DIV))
                    q = spsr_pkg::DELTA_W'(k);
            end
            delta = x[spsr_pkg::X_W-1] ? -q : q;
        end
        req_gap  = {1'b0, requested_reg} - {1'b0, item_count_reg};
        near_end = req_gap < $signed((spsr_pkg::COUNT_W + 1)'(spsr_pkg::NEAR_END));
    end

    // missed pulse counter and magnitudes
    always_comb
    begin
        crit     = div_dvd_reg[spsr_pkg::CRIT_W-1:0];
        miss_sel = group_a_reg ? miss_a_reg : miss_b_reg;
        c_new    = miss_sel + spsr_pkg::MISS_W'(1);
        // |c| and |c + 1| without a second negate
        abs0     = c_new[spsr_pkg::MISS_W-1] ? ~miss_sel : c_new;
        abs1     = c_reg[spsr_pkg::MISS_W-1] ? ~c_reg : c_reg + spsr_pkg::MISS_W'(1);
        step     = spsr_pkg::step_lookup(speed_reg);
    end

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scale_reg      <= spsr_pkg::SCALE_W'(1);
            last_a_reg     <= '1;
            last_b_reg     <= '1;
            miss_a_reg     <= '1;
            miss_b_reg     <= '1;
            motor_reg      <= '0;
            group_a_reg    <= 1'b0;
            period_reg     <= '0;
            item_count_reg <= '0;
            requested_reg  <= '0;
            speed_reg      <= '0;
            div_dvd_reg    <= '0;
            div_dsr_reg    <= '0;
            div_rem_reg    <= '0;
            div_cnt_reg    <= '0;
            c_reg          <= '0;
            dev_reg        <= '0;
            q4_reg         <= '0;
            pend_cmd_reg   <= spsr_pkg::CMD_ABS;
            pend_value_reg <= '0;
            pend_delta_reg <= '0;
            pend_err_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_cmd_reg    <= spsr_pkg::CMD_ABS;
            out_motor_reg  <= '0;
            out_value_reg  <= '0;
            out_delta_reg  <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            // configuration write
            if (cfg.valid && cfg.ready)
                scale_reg <= cfg.data;

            // output transaction taken; the emit state reloads the register itself
            if (result.valid && result.ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && motor_ok)
                    begin
                        motor_reg      <= pulse.motor_index;
                        group_a_reg    <= group_in;
                        period_reg     <= pulse.pulse_period;
                        item_count_reg <= pulse.pulse_count;
                        requested_reg  <= pulse.requested_count;
                        speed_reg      <= pulse.current_speed;
                        // divide error command, replaced below where no error
                        pend_cmd_reg   <= spsr_pkg::CMD_ABS;
                        pend_value_reg <= '0;
                        pend_delta_reg <= '0;
                        pend_err_reg   <= 1'b1;
                        div_dsr_reg    <= spsr_pkg::DSR_W'(pulse.wanted_speed);
                        div_rem_reg    <= '0;
                        unique case (in_mode)
                            spsr_pkg::MODE_PULSE:
                            begin
                                if (pulse.pulse_period != '0)
                                begin
                                    if (pulse.wanted_speed == '0)
                                        state_reg <= ST_EMIT;
                                    else
                                    begin
                                        div_dvd_reg <= {scaled,
                                            (spsr_pkg::DVD_W - spsr_pkg::TARGET_W)'(0)};
                                        div_cnt_reg <= spsr_pkg::CNT_W'(spsr_pkg::TARGET_W);
                                        state_reg   <= ST_TARGET;
                                    end
                                end
                            end
                            spsr_pkg::MODE_MISS:
                            begin
                                if (pulse.wanted_speed == '0)
                                    state_reg <= ST_EMIT;
                                else
                                begin
                                    div_dvd_reg <= {crit_num,
                                        (spsr_pkg::DVD_W - spsr_pkg::CRIT_W)'(0)};
                                    div_cnt_reg <= spsr_pkg::CNT_W'(spsr_pkg::CRIT_W);
                                    state_reg   <= ST_CRIT;
                                end
                            end
                            spsr_pkg::MODE_RESET:
                            begin
                                if (group_in)
                                begin
                                    miss_a_reg <= '1;
                                    last_a_reg <= '1;
                                end
                                else
                                begin
                                    miss_b_reg <= '1;
                                    last_b_reg <= '1;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // target period divide
                ST_TARGET:
                begin
                    div_dvd_reg <= div_dvd_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - spsr_pkg::CNT_W'(1);
                    if (div_last)
                        state_reg <= ST_EVAL0;
                end

                // error and trend terms, group state update
                ST_EVAL0:
                begin
                    dev_reg <= period_x - target_x;
                    q4_reg  <= prev_adj >>> spsr_pkg::PREV_SHIFT;
                    if (group_a_reg)
                    begin
                        last_a_reg <= spsr_pkg::LAST_W'(period_reg);
                        if (item_count_reg > spsr_pkg::COUNT_W'(1))
                            miss_a_reg <= '1;
                    end
                    else
                    begin
                        last_b_reg <= spsr_pkg::LAST_W'(period_reg);
                        if (item_count_reg > spsr_pkg::COUNT_W'(1))
                            miss_b_reg <= '1;
                    end
                    state_reg <= ST_EVAL1;
                end

                // absolute speed near the end of the move, else a delta
                ST_EVAL1:
                begin
                    pend_err_reg <= 1'b0;
                    if (near_end)
                    begin
                        pend_cmd_reg   <= spsr_pkg::CMD_ABS;
                        pend_value_reg <= (speed_reg > spsr_pkg::SPEED_W'(spsr_pkg::FAST_LIMIT))
                                        ? spsr_pkg::SPEED_W'(spsr_pkg::END_SPEED_FAST)
                                        : spsr_pkg::SPEED_W'(spsr_pkg::END_SPEED_SLOW);
                        pend_delta_reg <= '0;
                    end
                    else
                    begin
                        pend_cmd_reg   <= spsr_pkg::CMD_DELTA;
                        pend_value_reg <= '0;
                        pend_delta_reg <= delta;
                    end
                    state_reg <= ST_EMIT;
                end

                // critical count divide
                ST_CRIT:
                begin
                    div_dvd_reg <= div_dvd_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - spsr_pkg::CNT_W'(1);
                    if (div_last)
                        state_reg <= ST_CNT;
                end

                // advance the group counter, start |c| mod K; a zero K emits a divide error
                ST_CNT:
                begin
                    if (crit == '0)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        if (group_a_reg)
                            miss_a_reg <= c_new;
                        else
                            miss_b_reg <= c_new;
                        c_reg       <= c_new;
                        div_dvd_reg <= abs0;
                        div_dsr_reg <= crit;
                        div_rem_reg <= '0;
                        div_cnt_reg <= spsr_pkg::CNT_W'(spsr_pkg::DVD_W);
                        state_reg   <= ST_MODA;
                    end
                end

                // |c| mod K; on zero step up the table
                ST_MODA:
                begin
                    if (div_last)
                    begin
                        pend_err_reg   <= 1'b0;
                        pend_cmd_reg   <= spsr_pkg::CMD_ABS;
                        pend_delta_reg <= '0;
                        pend_value_reg <= step.value;
                        if (div_rem_next == '0)
                            state_reg <= step.hit ? ST_EMIT : ST_IDLE;
                        else if (abs1[spsr_pkg::FULL_SHIFT-1:0] != '0)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            // |c + 1| mod 16K via (|c + 1| / 16) mod K
                            div_dvd_reg <= spsr_pkg::DVD_W'(abs1 >> spsr_pkg::FULL_SHIFT);
                            div_rem_reg <= '0;
                            div_cnt_reg <= spsr_pkg::CNT_W'(spsr_pkg::DVD_W);
                            state_reg   <= ST_MODB;
                        end
                    end
                    else
                    begin
                        div_dvd_reg <= div_dvd_next;
                        div_rem_reg <= div_rem_next;
                        div_cnt_reg <= div_cnt_reg - spsr_pkg::CNT_W'(1);
                    end
                end

                // on zero go to full speed
                ST_MODB:
                begin
                    div_dvd_reg <= div_dvd_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - spsr_pkg::CNT_W'(1);
                    if (div_last)
                    begin
                        pend_value_reg <= spsr_pkg::SPEED_W'(spsr_pkg::MAX_SPEED);
                        state_reg      <= (div_rem_next == '0) ? ST_EMIT : ST_IDLE;
                    end
                end

                // hand the command to the output register once it is free
                ST_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cmd_reg   <= pend_cmd_reg;
                        out_motor_reg <= motor_reg;
                        out_value_reg <= pend_value_reg;
                        out_delta_reg <= pend_delta_reg;
                        out_err_reg   <= pend_err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // remainder stays below the divisor through every modulo pass
    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODA || state_reg == ST_MODB) |-> div_rem_reg < div_dsr_reg)
        else $error("divider remainder not below divisor");

    // divide states always have steps left
    a_div_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TARGET || state_reg == ST_CRIT || state_reg == ST_MODA
         || state_reg == ST_MODB) |-> div_cnt_reg != '0)
        else $error("divider running with no steps left");

    // a group A reset transaction leaves that group's counter and last period at minus one
    a_group_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_mode == spsr_pkg::MODE_RESET && motor_ok && group_in)
        |=> miss_a_reg == '1 && last_a_reg == '1)
        else $error("group reset did not clear group state");

    // a new command only appears out of the emit state
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("command loaded outside the emit state");

endmodule
